// ----- src/vu_level_meter_assert.svh -----
`ifndef VU_LEVEL_METER_ASSERT_SVH
`define VU_LEVEL_METER_ASSERT_SVH

// concurrent check on aclk, held off while aresetn is low
`define VULM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check on aclk that also looks across reset
`define VULM_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/vulm_pkg.sv -----
`timescale 1ns / 1ps

package vulm_pkg;

    // fixed field widths
    localparam int NUM_INPUTS = 8;
    localparam int COUNT_BITS = 4;
    localparam int COEFF_BITS = 17;
    localparam int LEVEL_BITS = 32;
    localparam int INDEX_BITS = 2;
    localparam int FRAC_BITS  = 16;

    // parameter defaults
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [COEFF_BITS-1:0] coeff_t;
    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [INDEX_BITS-1:0] cfg_index_t;

    // 1.0 in Q1.16
    localparam coeff_t COEFF_ONE = coeff_t'(65536);

    // register map and reset values
    localparam cfg_index_t REG_CHANNEL_COUNT = cfg_index_t'(0);
    localparam cfg_index_t REG_ATTACK_COEFF  = cfg_index_t'(1);
    localparam cfg_index_t REG_RELEASE_COEFF = cfg_index_t'(2);

    localparam count_t COUNT_RESET   = count_t'(1);
    localparam coeff_t ATTACK_RESET  = coeff_t'(6554);
    localparam coeff_t RELEASE_RESET = coeff_t'(66);

endpackage

// ----- src/vu_level_meter.sv -----
`timescale 1ns / 1ps

// channel   direction  ports
// --------  ---------  -------------------------------------------------
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
// frame     in         s_valid, s_ready, s_sample_0 .. s_sample_7
// level     out        m_valid, m_ready, m_level_out
//
// one frame in flight: a frame is summed, divided and used to update the level before the
// next frame is taken. the two-bit-per-cycle divider does the averaging, the shared
// multiplier of the level update does the attack and release steps.
// aresetn (synchronous) clears the level to zero and loads the register reset values.
// a held result word stalls the finished frame before its level is handed to the output,
// the next frame is taken as soon as the result sits in the output register.
module vu_level_meter #(
    parameter int MAX_CHANNELS = vulm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = vulm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  vulm_pkg::cfg_index_t                  cfg_index,
    input  logic [vulm_pkg::COEFF_BITS-1:0]       cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_0,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_1,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_2,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_3,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_4,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_5,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_6,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_7,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output vulm_pkg::level_t                      m_level_out
);

    import vulm_pkg::*;

    localparam int ABS_BITS = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int MAG_BITS = ABS_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(MAX_CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } top_state_t;

    top_state_t          state_reg, state_next;
    count_t              count_reg, count_next;
    coeff_t              attack_reg, attack_next;
    coeff_t              release_reg, release_next;
    logic [CNT_BITS-1:0] used_reg, used_next;
    logic                m_valid_reg, m_valid_next;
    level_t              m_level_reg, m_level_next;

    logic                accept_in;
    logic                cfg_write;
    count_t              eff_wide;
    logic [CNT_BITS-1:0] eff_count;
    logic [MAX_CHANNELS-1:0] lane_on;
    logic                merge_load, div_start, div_done, upd_start, upd_done;

    logic signed [SAMPLE_BITS-1:0] sample_in [NUM_INPUTS];
    logic signed [SAMPLE_BITS-1:0] lane_val [MAX_CHANNELS];
    logic [ABS_BITS-1:0] abs_sum;
    logic [MAG_BITS-1:0] mag;
    level_t              level;

    assign sample_in[0] = s_sample_0;
    assign sample_in[1] = s_sample_1;
    assign sample_in[2] = s_sample_2;
    assign sample_in[3] = s_sample_3;
    assign sample_in[4] = s_sample_4;
    assign sample_in[5] = s_sample_5;
    assign sample_in[6] = s_sample_6;
    assign sample_in[7] = s_sample_7;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // zero counts as one channel, large counts clamp to the lane count
    always_comb begin
        if (count_reg == '0) begin
            eff_wide = COUNT_BITS'(1);
        end else if (count_reg > COUNT_BITS'(MAX_CHANNELS)) begin
            eff_wide = COUNT_BITS'(MAX_CHANNELS);
        end else begin
            eff_wide = count_reg;
        end
        eff_count = CNT_BITS'(eff_wide);
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            lane_on[i] = CNT_BITS'(i) < eff_count;
        end
    end

    // sample lanes
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        vulm_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk   (aclk),
            .load   (accept_in),
            .active (lane_on[i]),
            .sample (sample_in[i]),
            .value  (lane_val[i])
        );
    end

    vulm_merge #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_merge (
        .aclk     (aclk),
        .load     (merge_load),
        .lane_val (lane_val),
        .abs_sum  (abs_sum)
    );

    vulm_div #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .abs_sum (abs_sum),
        .divisor (used_reg),
        .done    (div_done),
        .mag     (mag)
    );

    vulm_update #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_update (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (upd_start),
        .mag           (mag),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .done          (upd_done),
        .level         (level)
    );

    // frame sequencing, register writes and the output word
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        used_next    = used_reg;
        m_valid_next = m_valid_reg;
        m_level_next = m_level_reg;
        merge_load   = 1'b0;
        div_start    = 1'b0;
        upd_start    = 1'b0;

        if (cfg_write) begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: count_next   = cfg_data[COUNT_BITS-1:0];
                REG_ATTACK_COEFF:  attack_next  = cfg_data;
                REG_RELEASE_COEFF: release_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    used_next  = eff_count;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                merge_load = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    upd_start  = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (upd_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_level_next = level;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RESET;
            attack_reg  <= ATTACK_RESET;
            release_reg <= RELEASE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            m_valid_reg <= m_valid_next;
        end
        used_reg    <= used_next;
        m_level_reg <= m_level_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_level_out = m_level_reg;

endmodule

// ----- src/vulm_lane.sv -----
`timescale 1ns / 1ps

module vulm_lane #(
    parameter int SAMPLE_BITS = vulm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          active,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;

    // channels beyond the active count contribute nothing
    always_comb begin
        value_next = active ? sample : '0;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ----- src/vulm_merge.sv -----
`timescale 1ns / 1ps

module vulm_merge #(
    parameter int MAX_CHANNELS = vulm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = vulm_pkg::SAMPLE_BITS_DEF,
    localparam int ABS_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS)
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] lane_val [MAX_CHANNELS],
    output logic [ABS_BITS-1:0]           abs_sum
);

    localparam int SUM_BITS = ABS_BITS + 1;

    logic signed [SUM_BITS-1:0] sum;
    logic [ABS_BITS-1:0]        abs_reg;
    logic [ABS_BITS-1:0]        abs_next;

    // add the lane words and take the magnitude
    always_comb begin
        sum = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            sum = sum + SUM_BITS'(lane_val[i]);
        end
        abs_next = sum[SUM_BITS-1] ? ABS_BITS'(-sum) : ABS_BITS'(sum);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            abs_reg <= abs_next;
        end
    end

    assign abs_sum = abs_reg;

endmodule

// ----- src/vulm_div.sv -----
`timescale 1ns / 1ps

module vulm_div #(
    parameter int MAX_CHANNELS = vulm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = vulm_pkg::SAMPLE_BITS_DEF,
    localparam int ABS_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS),
    localparam int MAG_BITS    = ABS_BITS + vulm_pkg::FRAC_BITS,
    localparam int CNT_BITS    = $clog2(MAX_CHANNELS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ABS_BITS-1:0] abs_sum,
    input  logic [CNT_BITS-1:0] divisor,
    output logic                done,
    output logic [MAG_BITS-1:0] mag
);

    import vulm_pkg::*;

    // two quotient bits per cycle
    localparam int STEPS     = (MAG_BITS + 1) / 2;
    localparam int DVD_BITS  = 2 * STEPS;
    localparam int ITER_BITS = $clog2(STEPS + 1);

    logic [DVD_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_BITS-1:0]  rem_reg, rem_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [CNT_BITS:0]    trial_a, trial_b;
    logic [CNT_BITS-1:0]  rem_mid, rem_end;
    logic                 bit_a, bit_b;

    // restoring long division, first and second bit of the cycle
    always_comb begin
        trial_a = {rem_reg, quo_reg[DVD_BITS-1]};
        bit_a   = trial_a >= {1'b0, divisor};
        rem_mid = bit_a ? CNT_BITS'(trial_a - {1'b0, divisor}) : trial_a[CNT_BITS-1:0];
        trial_b = {rem_mid, quo_reg[DVD_BITS-2]};
        bit_b   = trial_b >= {1'b0, divisor};
        rem_end = bit_b ? CNT_BITS'(trial_b - {1'b0, divisor}) : trial_b[CNT_BITS-1:0];
    end

    // iteration control
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = DVD_BITS'({abs_sum, {FRAC_BITS{1'b0}}});
            rem_next  = '0;
            iter_next = ITER_BITS'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DVD_BITS-3:0], bit_a, bit_b};
            rem_next  = rem_end;
            iter_next = iter_reg - ITER_BITS'(1);
            if (iter_reg == ITER_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign mag  = quo_reg[MAG_BITS-1:0];

endmodule

// ----- src/vulm_update.sv -----
`timescale 1ns / 1ps

module vulm_update #(
    parameter int MAX_CHANNELS = vulm_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = vulm_pkg::SAMPLE_BITS_DEF,
    localparam int MAG_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS) + vulm_pkg::FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MAG_BITS-1:0]  mag,
    input  vulm_pkg::coeff_t     attack_coeff,
    input  vulm_pkg::coeff_t     release_coeff,
    output logic                 done,
    output vulm_pkg::level_t     level
);

    import vulm_pkg::*;

    localparam int HI_BITS   = (MAG_BITS > LEVEL_BITS) ? MAG_BITS - LEVEL_BITS : 1;
    localparam int EXT_BITS  = LEVEL_BITS + HI_BITS;
    localparam int PROD_BITS = LEVEL_BITS + COEFF_BITS;
    localparam int HIP_BITS  = HI_BITS + COEFF_BITS;
    localparam int FULL_BITS = EXT_BITS + COEFF_BITS;
    localparam int RISE_BITS = FULL_BITS - FRAC_BITS;
    localparam int NEXT_BITS = RISE_BITS + 1;

    typedef enum logic [2:0] {
        U_IDLE,
        U_KEEP,
        U_LO,
        U_HI,
        U_SUM,
        U_FIN
    } upd_state_t;

    upd_state_t           state_reg, state_next;
    level_t               level_reg, level_next;
    logic                 done_reg, done_next;
    logic                 attack_reg, attack_next;
    level_t               keep_reg, keep_next;
    logic [PROD_BITS-1:0] lo_reg, lo_next;
    logic [HIP_BITS-1:0]  hi_reg, hi_next;
    logic [RISE_BITS-1:0] rise_reg, rise_next;

    logic [EXT_BITS-1:0]  mag_ext;
    coeff_t               atk_sat, rel_sat;
    level_t               mul_a;
    coeff_t               mul_b;
    logic [PROD_BITS-1:0] prod;
    logic [NEXT_BITS-1:0] next_wide;

    // coefficients above 1.0 clamp to 1.0
    always_comb begin
        atk_sat = (attack_coeff > COEFF_ONE) ? COEFF_ONE : attack_coeff;
        rel_sat = (release_coeff > COEFF_ONE) ? COEFF_ONE : release_coeff;
        mag_ext = EXT_BITS'(mag);
    end

    // shared 32x17 multiplier, operands picked by step
    always_comb begin
        mul_a = level_reg;
        mul_b = '0;
        case (state_reg)
            U_KEEP: begin
                mul_a = level_reg;
                mul_b = COEFF_ONE - (attack_reg ? atk_sat : rel_sat);
            end
            U_LO: begin
                mul_a = mag_ext[LEVEL_BITS-1:0];
                mul_b = atk_sat;
            end
            U_HI: begin
                mul_a = LEVEL_BITS'(mag_ext[EXT_BITS-1:LEVEL_BITS]);
                mul_b = atk_sat;
            end
            default: begin
                mul_a = level_reg;
                mul_b = '0;
            end
        endcase
        prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    // new level with saturation
    always_comb begin
        if (attack_reg) begin
            next_wide = NEXT_BITS'(keep_reg) + NEXT_BITS'(rise_reg);
        end else begin
            next_wide = NEXT_BITS'(keep_reg);
        end
    end

    // step sequencer
    always_comb begin
        state_next  = state_reg;
        level_next  = level_reg;
        done_next   = 1'b0;
        attack_next = attack_reg;
        keep_next   = keep_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        rise_next   = rise_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    attack_next = mag_ext > EXT_BITS'(level_reg);
                    state_next  = U_KEEP;
                end
            end
            U_KEEP: begin
                keep_next  = LEVEL_BITS'(prod >> FRAC_BITS);
                state_next = U_LO;
            end
            U_LO: begin
                lo_next    = prod;
                state_next = U_HI;
            end
            U_HI: begin
                hi_next    = HIP_BITS'(prod);
                state_next = U_SUM;
            end
            U_SUM: begin
                rise_next  = RISE_BITS'(({hi_reg, {LEVEL_BITS{1'b0}}}
                                         + FULL_BITS'(lo_reg)) >> FRAC_BITS);
                state_next = U_FIN;
            end
            U_FIN: begin
                level_next = (|next_wide[NEXT_BITS-1:LEVEL_BITS]) ? '1
                                                                  : next_wide[LEVEL_BITS-1:0];
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
        attack_reg <= attack_next;
        keep_reg   <= keep_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rise_reg   <= rise_next;
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

// ----- src/vulm_checker.sv -----
`timescale 1ns / 1ps
`include "vu_level_meter_assert.svh"

module vulm_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input vulm_pkg::level_t m_level_out
);

    // a held result word keeps its level
    `VULM_CHECK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_level_out), "level word changed while stalled")

    // reset leaves no word pending and the frame side open
    `VULM_CHECK_RST(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

    // one frame at a time
    `VULM_CHECK(a_one_frame, s_valid && s_ready |=> !s_ready, "second frame taken while busy")

    // the frame side stays open until a frame arrives
    `VULM_CHECK(a_ready_waits, s_ready && !s_valid |=> s_ready, "ready dropped without a frame")

endmodule

bind vu_level_meter vulm_checker u_vulm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_level_out (m_level_out)
);

// ----- sim/tb_vu_level_meter.sv -----
`timescale 1ns / 1ps

module tb_vu_level_meter;
    import vulm_pkg::*;

    localparam int SMP_BITS         = SAMPLE_BITS_DEF;
    localparam int CHANNELS         = MAX_CHANNELS_DEF;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 60;
    localparam int RANDOM_PHASES    = 6;
    localparam int FRAMES_PER_PHASE = 90;
    localparam int MAX_GAP          = 40;
    localparam int MAX_SHOWN        = 40;
    localparam int IDLE_PCT         = 34;
    // index with no register behind it, writes must be dropped
    localparam cfg_index_t REG_UNUSED = cfg_index_t'(3);

    typedef logic [NUM_INPUTS-1:0][SMP_BITS-1:0] frame_t;

    // one row of the directed table: a register write or a frame
    typedef struct packed {
        logic       is_write;
        cfg_index_t idx;
        coeff_t     data;
        frame_t     frame;
        logic       typed;
        level_t     want;
    } row_t;

    // typed expectation that travels with a frame to its accept
    typedef struct packed {
        logic   typed;
        level_t want;
    } mark_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_CHANNEL_COUNT;
    coeff_t     cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    frame_t     s_frame   = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    level_t     m_level_out;

    // predictor state
    count_t     model_count   = COUNT_RESET;
    coeff_t     model_attack  = ATTACK_RESET;
    coeff_t     model_release = RELEASE_RESET;
    level_t     model_level   = '0;

    level_t     pending_levels[$];
    mark_t      frame_marks[$];
    row_t       directed_rows[$];

    int src_idle_pct  = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;
    int mismatches    = 0;
    int frames_in     = 0;
    int results_seen  = 0;
    int writes_done   = 0;
    int rises         = 0;
    int decays        = 0;
    int quiet_cycles  = 0;

    vu_level_meter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_0  (s_frame[0]),
        .s_sample_1  (s_frame[1]),
        .s_sample_2  (s_frame[2]),
        .s_sample_3  (s_frame[3]),
        .s_sample_4  (s_frame[4]),
        .s_sample_5  (s_frame[5]),
        .s_sample_6  (s_frame[6]),
        .s_sample_7  (s_frame[7]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level_out (m_level_out)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // envelope update for one frame: average magnitude, then attack or release
    function automatic level_t next_meter_level(frame_t f, count_t cnt, coeff_t atk,
                                                coeff_t rel, level_t lvl, output bit rising);
        longint     sum;
        bit [63:0]  n;
        bit [63:0]  abs_sum;
        bit [63:0]  mag;
        bit [63:0]  coef;
        bit [63:0]  lvl64;
        bit [63:0]  nxt;
        bit [63:0]  one;
        one   = 64'd1 << FRAC_BITS;
        lvl64 = 64'(lvl);
        if (cnt == 0)
            n = 1;
        else if (cnt > CHANNELS)
            n = CHANNELS;
        else
            n = 64'(cnt);
        sum = 0;
        for (int c = 0; c < CHANNELS; c++)
            if (c < n)
                sum += longint'($signed(f[c]));
        abs_sum = (sum < 0) ? 64'(-sum) : 64'(sum);
        mag     = (abs_sum << FRAC_BITS) / n;
        rising  = (mag > lvl64);
        if (rising) begin
            coef = (atk > COEFF_ONE) ? 64'(COEFF_ONE) : 64'(atk);
            nxt  = ((lvl64 * (one - coef)) >> FRAC_BITS) + ((mag * coef) >> FRAC_BITS);
        end else begin
            coef = (rel > COEFF_ONE) ? 64'(COEFF_ONE) : 64'(rel);
            nxt  = (lvl64 * (one - coef)) >> FRAC_BITS;
        end
        if (nxt > 64'hFFFF_FFFF)
            nxt = 64'hFFFF_FFFF;
        return level_t'(nxt);
    endfunction

    task automatic report_mismatch(string what, level_t got, level_t want);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch (%s) at result %0d: level_out %h, expected %h",
                     what, results_seen, got, want);
    endtask

    // track config, predict on frame accept, check on level accept
    always @(posedge aclk) begin
        mark_t  mk;
        level_t lvl;
        bit     up;
        if (!aresetn) begin
            model_count   = COUNT_RESET;
            model_attack  = ATTACK_RESET;
            model_release = RELEASE_RESET;
            model_level   = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: model_count   = count_t'(cfg_data);
                    REG_ATTACK_COEFF:  model_attack  = cfg_data;
                    REG_RELEASE_COEFF: model_release = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_levels.size() == 0)
                    report_mismatch("unexpected word", m_level_out, '0);
                else begin
                    lvl = pending_levels.pop_front();
                    if (m_level_out !== lvl)
                        report_mismatch("level_out", m_level_out, lvl);
                end
            end
            if (s_valid && s_ready) begin
                frames_in++;
                lvl = next_meter_level(s_frame, model_count, model_attack, model_release,
                                       model_level, up);
                if (up)
                    rises++;
                else
                    decays++;
                mk = (frame_marks.size() != 0) ? frame_marks.pop_front() : '0;
                if (mk.typed)
                    lvl = mk.want;
                model_level = lvl;
                pending_levels.push_back(lvl);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d words outstanding",
                         quiet_cycles, pending_levels.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic frame_t fill(logic [SMP_BITS-1:0] first, logic [SMP_BITS-1:0] rest);
        frame_t f;
        for (int c = 0; c < NUM_INPUTS; c++)
            f[c] = rest;
        f[0] = first;
        return f;
    endfunction

    function automatic row_t frame_row(frame_t f, logic typed, level_t want);
        row_t r;
        r          = '0;
        r.frame    = f;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    function automatic row_t write_row(cfg_index_t idx, coeff_t data);
        row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        return r;
    endfunction

    function automatic logic [SMP_BITS-1:0] small_sample();
        logic [SMP_BITS-1:0] v;
        v = SMP_BITS'($urandom_range(255));
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic logic [SMP_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3:       return small_sample();
            default: return SMP_BITS'($urandom);
        endcase
    endfunction

    // quiet frames let the level decay between louder ones
    function automatic frame_t rand_frame();
        frame_t f;
        bit     quiet;
        quiet = ($urandom_range(99) < 30);
        for (int c = 0; c < NUM_INPUTS; c++)
            f[c] = quiet ? small_sample() : rand_sample();
        return f;
    endfunction

    function automatic coeff_t rand_coeff();
        case ($urandom_range(4))
            0:       return '0;
            1:       return COEFF_ONE;
            2:       return 17'h1FFFF;
            3:       return coeff_t'($urandom_range(65536));
            default: return coeff_t'($urandom_range(8192));
        endcase
    endfunction

    // channel count in the low nibble, junk above it now and then
    function automatic coeff_t rand_count_word();
        coeff_t w;
        w = $urandom_range(1) ? coeff_t'($urandom_range(1, CHANNELS))
                              : coeff_t'($urandom_range(15));
        if ($urandom_range(3) == 0)
            w = w | (coeff_t'($urandom) & 17'h1FFF0);
        return w;
    endfunction

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, coeff_t data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        writes_done++;
    endtask

    // one frame word, with an optional random gap ahead of it
    task automatic send_frame(frame_t f, logic typed, level_t want);
        int    gap;
        mark_t mk;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, MAX_GAP);
            repeat (gap) @(negedge aclk);
        end
        mk.typed = typed;
        mk.want  = want;
        frame_marks.push_back(mk);
        s_frame = f;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        row_t r;

        // directed table, starting from the reset configuration
        directed_rows.push_back(frame_row(fill('0, '0), 1'b1, 32'd0));
        directed_rows.push_back(frame_row(fill(16'h8000, '0), 1'b1, 32'd214761472));
        directed_rows.push_back(frame_row(fill(16'h7FFF, 16'h8000), 1'b0, '0));
        directed_rows.push_back(frame_row(fill('0, 16'h7FFF), 1'b0, '0));
        // full attack jumps straight to the magnitude
        directed_rows.push_back(write_row(REG_ATTACK_COEFF, COEFF_ONE));
        directed_rows.push_back(frame_row(fill(16'h7FFF, '0), 1'b1, 32'h7FFF_0000));
        // full release drops to zero
        directed_rows.push_back(write_row(REG_RELEASE_COEFF, COEFF_ONE));
        directed_rows.push_back(frame_row(fill('0, '0), 1'b1, 32'd0));
        directed_rows.push_back(write_row(REG_CHANNEL_COUNT, coeff_t'(CHANNELS)));
        directed_rows.push_back(frame_row(fill(16'h8000, 16'h8000), 1'b1, 32'h8000_0000));
        // count above the channel limit, magnitude equal to level takes release
        directed_rows.push_back(write_row(REG_CHANNEL_COUNT, coeff_t'(15)));
        directed_rows.push_back(frame_row(fill(16'h8000, 16'h8000), 1'b1, 32'd0));
        // zero count averages one channel
        directed_rows.push_back(write_row(REG_CHANNEL_COUNT, '0));
        directed_rows.push_back(frame_row(fill(16'hFFFF, 16'h7FFF), 1'b1, 32'h0001_0000));
        // coefficient beyond 1.0 saturates
        directed_rows.push_back(write_row(REG_ATTACK_COEFF, 17'h1FFFF));
        directed_rows.push_back(frame_row(fill(16'h4000, 16'h8000), 1'b1, 32'h4000_0000));
        // zero coefficients hold the level
        directed_rows.push_back(write_row(REG_RELEASE_COEFF, '0));
        directed_rows.push_back(frame_row(fill('0, '0), 1'b1, 32'h4000_0000));
        directed_rows.push_back(write_row(REG_ATTACK_COEFF, '0));
        directed_rows.push_back(frame_row(fill(16'h8000, '0), 1'b1, 32'h4000_0000));
        // uneven counts, back to the reset coefficients
        directed_rows.push_back(write_row(REG_CHANNEL_COUNT, coeff_t'(3)));
        directed_rows.push_back(write_row(REG_ATTACK_COEFF, ATTACK_RESET));
        directed_rows.push_back(write_row(REG_RELEASE_COEFF, RELEASE_RESET));
        directed_rows.push_back(frame_row(fill(16'h7FFF, 16'h7FFF), 1'b0, '0));
        directed_rows.push_back(frame_row({16'h1, 16'h1, 16'h1, 16'h1,
                                           16'h1, 16'h0, 16'hFFFE, 16'h1}, 1'b0, '0));
        directed_rows.push_back(write_row(REG_CHANNEL_COUNT, coeff_t'(5)));
        directed_rows.push_back(frame_row(fill(16'h8001, 16'h1234), 1'b0, '0));
        directed_rows.push_back(write_row(REG_UNUSED, 17'h1FFFF));
        directed_rows.push_back(frame_row(fill('0, '0), 1'b0, '0));

        // reset
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed walk, register writes only once the level stream is drained
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.is_write) begin
                wait_drained();
                write_reg(r.idx, r.data);
            end else
                send_frame(r.frame, r.typed, r.want);
        end

        // random phases, each under its own setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            if (p == 0) begin
                write_reg(REG_CHANNEL_COUNT, coeff_t'(COUNT_RESET));
                write_reg(REG_ATTACK_COEFF, ATTACK_RESET);
                write_reg(REG_RELEASE_COEFF, RELEASE_RESET);
            end else begin
                write_reg(REG_CHANNEL_COUNT, rand_count_word());
                write_reg(REG_ATTACK_COEFF, rand_coeff());
                write_reg(REG_RELEASE_COEFF, rand_coeff());
            end
            // one phase runs flat out on both sides
            src_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
            sink_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
                // one phase holds off now and then until the output side catches up
                if (p == 4 && (i % 15) == 14)
                    wait_drained();
                send_frame(rand_frame(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d frames and %0d register writes, %0d level words checked",
                 frames_in, writes_done, results_seen);
        $display("%0d attack updates, %0d release updates, %0d mismatches",
                 rises, decays, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- vu_level_meter.f -----
+incdir+src
src/vulm_pkg.sv
src/vulm_lane.sv
src/vulm_merge.sv
src/vulm_div.sv
src/vulm_update.sv
src/vu_level_meter.sv
src/vulm_checker.sv
sim/tb_vu_level_meter.sv
